FILE: design/chps_pkg.sv
// ----------------------------------------------------------------------------
// chps_pkg
// Types and codes shared by the channel histogram block and its submodules.
// ----------------------------------------------------------------------------
package chps_pkg;

  localparam int OUT_W  = 22;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // channel select codes
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  // register indexes, taken from paddr[2]
  localparam logic REG_CHANNEL_SELECT = 1'b0;
  localparam logic REG_CANVAS_HEIGHT  = 1'b1;

  localparam logic [9:0] CANVAS_HEIGHT_RESET = 10'd125;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] blue_byte;
    logic [7:0] green_byte;
    logic [7:0] red_byte;
    logic [7:0] bin_index;
  } req_t;

  typedef struct packed {
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] bar_height;
    logic [OUT_W-1:0] peak_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0] channel_select;
    logic [9:0] canvas_height;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic inc;
    logic fetch;
    logic mul;
    logic prep;
    logic div_step;
    logic clr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_act;
    logic       in_range;
    logic       scale;
    logic       sweep_last;
    logic       div_last;
  } sts_t;

endpackage

FILE: design/chps_ram.sv
// ----------------------------------------------------------------------------
// chps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module chps_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/chps_cfg.sv
// ----------------------------------------------------------------------------
// chps_cfg
// APB register file: channel select and canvas height.
// ----------------------------------------------------------------------------
module chps_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chps_pkg::ADDR_W-1:0]   paddr,
  input  logic [chps_pkg::DATA_W-1:0]   pwdata,
  output logic [chps_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output chps_pkg::cfg_t                cfg
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_select <= chps_pkg::CH_BLUE;
      cfg.canvas_height  <= chps_pkg::CANVAS_HEIGHT_RESET;
    end else if (wr_en) begin
      if (reg_idx == chps_pkg::REG_CHANNEL_SELECT) begin
        cfg.channel_select <= pwdata[1:0];
      end else begin
        cfg.canvas_height <= pwdata[9:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == chps_pkg::REG_CANVAS_HEIGHT) begin
      prdata = chps_pkg::DATA_W'(cfg.canvas_height);
    end else begin
      prdata = chps_pkg::DATA_W'(cfg.channel_select);
    end
  end

endmodule

FILE: design/chps_ctrl.sv
// ----------------------------------------------------------------------------
// chps_ctrl
// Sequencer: clear sweep, pixel update, bin read with scaling, result hand-off.
// ----------------------------------------------------------------------------
module chps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  chps_pkg::sts_t sts,
  output chps_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_INC,
    S_FETCH,
    S_MUL,
    S_PREP,
    S_DIV,
    S_CLEAR,
    S_DONE
  } state_t;

  state_t state;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_INIT:  cmd.clr      = 1'b1;
      S_IDLE:  cmd.latch    = req_valid;
      S_INC:   cmd.inc      = 1'b1;
      S_FETCH: cmd.fetch    = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_PREP:  cmd.prep     = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_CLEAR: cmd.clr      = 1'b1;
      S_DONE:  cmd.load_out = !rsp_valid || rsp_ready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (sts.sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            case (sts.req_act)
              chps_pkg::ACT_CLEAR: state <= S_CLEAR;
              chps_pkg::ACT_PIXEL: state <= sts.in_range ? S_INC : S_DONE;
              chps_pkg::ACT_READ:  state <= sts.in_range ? S_FETCH : S_DONE;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_INC:   state <= S_DONE;
        S_FETCH: state <= sts.scale ? S_MUL : S_DONE;
        S_MUL:   state <= S_PREP;
        S_PREP:  state <= S_DIV;
        S_DIV: begin
          if (sts.div_last) begin
            state <= S_DONE;
          end
        end
        S_CLEAR: begin
          if (sts.sweep_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/chps_datapath.sv
// ----------------------------------------------------------------------------
// chps_datapath
// Bin addressing, saturating increment, peak tracking, bar scaling by a
// multiply and a restoring divider, and the result register.
// ----------------------------------------------------------------------------
module chps_datapath #(
  parameter int NUM_BINS   = 256,
  parameter int COUNT_BITS = 22
) (
  input  logic                        clk,
  input  logic                        rst,
  input  chps_pkg::req_t              req,
  input  chps_pkg::cfg_t              cfg,
  input  chps_pkg::cmd_t              cmd,
  output chps_pkg::sts_t              sts,
  output logic                        ram_we,
  output logic [$clog2(NUM_BINS)-1:0] ram_waddr,
  output logic [COUNT_BITS-1:0]       ram_wdata,
  output logic [$clog2(NUM_BINS)-1:0] ram_raddr,
  input  logic [COUNT_BITS-1:0]       ram_rdata,
  output chps_pkg::rsp_t              rsp
);

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int PROD_W = COUNT_BITS + 10;
  localparam int NUM_W  = COUNT_BITS + 11;
  localparam int DCNT_W = $clog2(NUM_W);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [7:0]            sample;
  logic [7:0]            req_index;
  logic [BIN_W-1:0]      addr;
  logic [BIN_W-1:0]      sweep;
  logic [DCNT_W-1:0]     div_cnt;
  logic [COUNT_BITS-1:0] peak;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] bar;
  logic [COUNT_BITS-1:0] inc_value;
  logic [PROD_W-1:0]     prod;
  logic [NUM_W-1:0]      num;
  logic [NUM_W-1:0]      num_next;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] rem_next;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  ge;

  // channel 3 falls back to blue
  always_comb begin
    case (cfg.channel_select)
      chps_pkg::CH_GREEN: sample = req.green_byte;
      chps_pkg::CH_RED:   sample = req.red_byte;
      default:            sample = req.blue_byte;
    endcase
  end

  assign req_index = (req.action == chps_pkg::ACT_READ) ? req.bin_index : sample;
  assign ram_raddr = BIN_W'(req_index);

  assign inc_value = (ram_rdata != COUNT_MAX) ? ram_rdata + COUNT_BITS'(1) : ram_rdata;
  assign ram_we    = cmd.inc | cmd.clr;
  assign ram_waddr = cmd.clr ? sweep : addr;
  assign ram_wdata = cmd.clr ? '0 : inc_value;

  // one quotient bit per step; numerator shifts out, quotient shifts in
  assign rem_sh   = {rem, num[NUM_W-1]};
  assign ge       = (rem_sh >= {1'b0, peak});
  assign rem_next = ge ? COUNT_BITS'(rem_sh - {1'b0, peak}) : COUNT_BITS'(rem_sh);
  assign num_next = {num[NUM_W-2:0], ge};

  assign sts.req_act    = req.action;
  assign sts.in_range   = (32'(req_index) < 32'(NUM_BINS));
  assign sts.scale      = (32'(peak) > 32'(cfg.canvas_height));
  assign sts.sweep_last = (sweep == BIN_W'(NUM_BINS - 1));
  assign sts.div_last   = (div_cnt == DCNT_W'(NUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      peak    <= '0;
      sweep   <= '0;
      div_cnt <= '0;
    end else begin
      if (cmd.latch) begin
        sweep <= '0;
      end
      if (cmd.clr) begin
        sweep <= sweep + BIN_W'(1);
        peak  <= '0;
      end
      if (cmd.inc && (inc_value > peak)) begin
        peak <= inc_value;
      end
      if (cmd.prep) begin
        div_cnt <= '0;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      addr  <= BIN_W'(req_index);
      count <= '0;
      bar   <= '0;
    end
    if (cmd.fetch) begin
      count <= ram_rdata;
      bar   <= ram_rdata;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(count) * PROD_W'(cfg.canvas_height);
    end
    if (cmd.prep) begin
      // bias for a rounded-up quotient
      num <= NUM_W'(prod) + NUM_W'(peak) - NUM_W'(1);
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= rem_next;
      num <= num_next;
      if (sts.div_last) begin
        bar <= COUNT_BITS'(num_next);
      end
    end
    if (cmd.load_out) begin
      rsp.bin_count  <= chps_pkg::OUT_W'(count);
      rsp.bar_height <= chps_pkg::OUT_W'(bar);
      rsp.peak_count <= chps_pkg::OUT_W'(peak);
    end
  end

endmodule

FILE: design/channel_histogram_peak_scale_top.sv
// ----------------------------------------------------------------------------
// channel_histogram_peak_scale_top
// Histogram of one selected color channel with running peak and scaled reads.
//
//   Port group      Dir  Handshake            Payload
//   req             in   req_valid/req_ready  chps_pkg::req_t
//   rsp             out  rsp_valid/rsp_ready  chps_pkg::rsp_t
//   apb             in   psel/penable/pready  paddr, pwdata, prdata
//
// Pixel and unscaled read: each beat is accepted, then the RAM accessed, then the result loaded.
// Scaled read: RAM fetch, multiply and divider setup, then the one-bit-per-cycle divider.
// Clear: one bin written per cycle on the RAM write port.
// After reset a sweep zeroes every bin of the RAM; req_ready stays low meanwhile.
// A finished result waits in the output register while the next beat enters.
// ----------------------------------------------------------------------------
module channel_histogram_peak_scale_top #(
  parameter int NUM_BINS   = 256,
  parameter int COUNT_BITS = 22
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  chps_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output chps_pkg::rsp_t              rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [chps_pkg::ADDR_W-1:0] paddr,
  input  logic [chps_pkg::DATA_W-1:0] pwdata,
  output logic [chps_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int BIN_W = $clog2(NUM_BINS);

  chps_pkg::cfg_t        cfg;
  chps_pkg::cmd_t        cmd;
  chps_pkg::sts_t        sts;
  logic                  ram_we;
  logic [BIN_W-1:0]      ram_waddr;
  logic [BIN_W-1:0]      ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;

  chps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  chps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  chps_datapath #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rsp       (rsp)
  );

  chps_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
